>>> hdl/deat_pkg.sv
// ----------------------------------------------------------------------------
// deat_pkg: shared types and constants of the entity aging table
// entry and result layouts, event and operation codes, sequencer states
// ----------------------------------------------------------------------------
package deat_pkg;

    localparam int MAX_ENTITIES_DEF = 64;

    localparam int ID_W    = 64;
    localparam int LIFE_W  = 16;
    localparam int VT_W    = 5;
    localparam int SCALE_W = 16;
    localparam int EV_W    = 3;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd2000;

    localparam logic OP_ADVERTISE = 1'b0;
    localparam logic OP_TICK      = 1'b1;

    typedef enum logic [EV_W-1:0] {
        EV_NONE      = 3'd0,
        EV_CONNECTED = 3'd1,
        EV_REFRESHED = 3'd2,
        EV_DEPARTED  = 3'd3,
        EV_DROPPED   = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LIFE_W-1:0] life;
    } t_entry;

    typedef struct packed {
        logic            op;
        logic [ID_W-1:0] adv_id;
        logic [VT_W-1:0] adv_vtime;
    } t_cmd;

    typedef struct packed {
        t_event          event_res;
        logic [ID_W-1:0] event_entity;
        logic            send_discover;
    } t_result;

    typedef struct packed {
        logic idle;
        logic shift;
        logic res_valid;
    } t_head_ctrl;

    function automatic logic [LIFE_W-1:0] sat_dec(input logic [LIFE_W-1:0] v);
        sat_dec = (v == '0) ? v : v - 1'b1;
    endfunction

endpackage

>>> hdl/deat_cell.sv
// ----------------------------------------------------------------------------
// deat_cell: one table slot of the rotating ring
// holds an identifier and its lifetime, takes its neighbor's slot on a shift
// ----------------------------------------------------------------------------
module deat_cell
    import deat_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_shift,
    input  t_entry i_entry,
    output t_entry o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

>>> hdl/deat_head.sv
// ----------------------------------------------------------------------------
// deat_head: sweep sequencer at the head of the ring
// walks every slot past the head once per item, refreshing, appending,
// aging and compacting on the fly, and builds the result
// ----------------------------------------------------------------------------
module deat_head
    import deat_pkg::*;
#(
    parameter int MAX_ENTITIES = MAX_ENTITIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  t_cmd               i_cmd,
    input  logic [SCALE_W-1:0] i_timer_scale,
    input  t_entry             i_head,
    input  t_entry             i_next,
    input  logic               i_res_ready,
    output t_head_ctrl         o_ctrl,
    output t_entry             o_tail,
    output t_result            o_res
);

    localparam int KW = $clog2(MAX_ENTITIES);
    localparam int CW = $clog2(MAX_ENTITIES + 1);
    localparam int PW = VT_W + SCALE_W;
    localparam logic [KW-1:0] LAST = KW'(MAX_ENTITIES - 1);

    t_state            r_state, n_state;
    logic [KW-1:0]     r_k, n_k;
    logic [CW-1:0]     r_count, n_count;
    logic              r_first, n_first;
    logic              r_found, n_found;
    logic              r_removed, n_removed;
    logic              r_op, n_op;
    logic [ID_W-1:0]   r_id, n_id;
    logic [LIFE_W-1:0] r_life, n_life;
    t_result           r_res, n_res;

    logic [PW-1:0]     w_prod;
    logic [LIFE_W-1:0] w_life;
    logic              w_live;
    logic [LIFE_W-1:0] w_dec_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_k       <= '0;
            r_count   <= '0;
            r_first   <= 1'b1;
            r_found   <= 1'b0;
            r_removed <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_count   <= n_count;
            r_first   <= n_first;
            r_found   <= n_found;
            r_removed <= n_removed;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_id   <= n_id;
        r_life <= n_life;
        r_res  <= n_res;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (r_k == LAST) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            ST_IDLE:   o_ctrl.idle      = 1'b1;
            ST_SWEEP:  o_ctrl.shift     = 1'b1;
            ST_FINISH: o_ctrl.res_valid = 1'b1;
            default:   o_ctrl = '0;
        endcase
    end

    assign w_prod     = PW'(i_cmd.adv_vtime) * PW'(i_timer_scale);
    assign w_life     = (|w_prod[PW-1:LIFE_W]) ? {LIFE_W{1'b1}} : w_prod[LIFE_W-1:0];
    assign w_live     = CW'(r_k) < r_count;
    assign w_dec_head = sat_dec(i_head.life);

    // sweep datapath
    always_comb begin
        n_k       = r_k;
        n_count   = r_count;
        n_first   = r_first;
        n_found   = r_found;
        n_removed = r_removed;
        n_op      = r_op;
        n_id      = r_id;
        n_life    = r_life;
        n_res     = r_res;
        o_tail    = i_head;

        if (i_start) begin
            n_op      = i_cmd.op;
            n_id      = i_cmd.adv_id;
            n_life    = w_life;
            n_k       = '0;
            n_found   = 1'b0;
            n_removed = 1'b0;
            if (i_cmd.op == OP_TICK) begin
                n_res   = '{event_res: EV_NONE, event_entity: '0, send_discover: r_first};
                n_first = 1'b0;
            end else begin
                n_res = '{event_res: EV_DROPPED, event_entity: i_cmd.adv_id,
                          send_discover: 1'b0};
            end
        end

        if (r_state == ST_SWEEP) begin
            n_k = r_k + 1'b1;
            if (r_op == OP_TICK) begin
                // after the expired slot is gone every later slot moves down one
                if (r_removed || (w_live && w_dec_head == '0)) begin
                    o_tail = '{id: i_next.id, life: sat_dec(i_next.life)};
                end else begin
                    o_tail = '{id: i_head.id, life: w_dec_head};
                end
                if (!r_removed && w_live && w_dec_head == '0) begin
                    n_removed              = 1'b1;
                    n_count                = r_count - 1'b1;
                    n_res.event_res        = EV_DEPARTED;
                    n_res.event_entity     = i_head.id;
                end
            end else begin
                if (w_live && !r_found && i_head.id == r_id) begin
                    o_tail          = '{id: i_head.id, life: r_life};
                    n_found         = 1'b1;
                    n_res.event_res = EV_REFRESHED;
                end else if (!r_found && CW'(r_k) == r_count) begin
                    // first free slot reached without a hit
                    o_tail          = '{id: r_id, life: r_life};
                    n_found         = 1'b1;
                    n_count         = r_count + 1'b1;
                    n_res.event_res = EV_CONNECTED;
                end
            end
        end
    end

    assign o_res = r_res;

endmodule

>>> hdl/discovery_entity_aging_table.sv
// ----------------------------------------------------------------------------
// discovery_entity_aging_table: ordered table of discovered entities with aging
// advertise items refresh or append an entry, or are dropped when the table is
// full; tick items age the table and retire the oldest expired entry
//
//  channel   dir   handshake              payload
//  s_axis    in    s_axis_tvalid/tready   tuser: operation
//                                         tdata: adv_id, adv_vtime
//  m_axis    out   m_axis_tvalid/tready   tuser: event_res, send_discover
//                                         tdata: event_entity
//  cfg       in    i_cfg_valid/o_cfg_ready  i_cfg_data: timer_scale
//
// the table is a ring of MAX_ENTITIES cells that rotates once past the head
// unit, one slot per cycle; the finish state then hands the result to the
// output register, and only the idle state takes the next item
// reset empties the table at once; the cell contents need no clearing
// a result waiting on m_axis_tready holds the next item's completion only
// ----------------------------------------------------------------------------
module discovery_entity_aging_table
    import deat_pkg::*;
#(
    parameter int MAX_ENTITIES = MAX_ENTITIES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [71:0]        s_axis_tdata,   // adv_id[63:0], adv_vtime[68:64], zero pad
    input  logic [0:0]         s_axis_tuser,   // operation[0]

    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [63:0]        m_axis_tdata,   // event_entity[63:0]
    output logic [3:0]         m_axis_tuser,   // event_res[2:0], send_discover[3]

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [SCALE_W-1:0] i_cfg_data
);

    logic [SCALE_W-1:0] r_timer_scale;
    logic               r_out_valid;
    t_result            r_out;

    t_head_ctrl w_ctrl;
    t_entry     w_tail;
    t_result    w_res;
    t_cmd       w_cmd;
    logic       w_start;
    logic       w_res_ready;
    t_entry     w_cell [MAX_ENTITIES];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer_scale <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_timer_scale <= i_cfg_data;
        end
    end

    assign s_axis_tready = w_ctrl.idle;
    assign w_start       = s_axis_tvalid && w_ctrl.idle;
    assign w_cmd = '{op: s_axis_tuser[0], adv_id: s_axis_tdata[ID_W-1:0],
                     adv_vtime: s_axis_tdata[ID_W+VT_W-1:ID_W]};

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTITIES; gi++) begin : g_ring
            t_entry w_in;
            if (gi == MAX_ENTITIES - 1) begin : g_tail
                assign w_in = w_tail;
            end else begin : g_link
                assign w_in = w_cell[gi+1];
            end
            deat_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_ctrl.shift),
                .i_entry (w_in),
                .o_entry (w_cell[gi])
            );
        end
    endgenerate

    deat_head #(
        .MAX_ENTITIES (MAX_ENTITIES)
    ) u_head (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (w_start),
        .i_cmd         (w_cmd),
        .i_timer_scale (r_timer_scale),
        .i_head        (w_cell[0]),
        .i_next        (w_cell[1]),
        .i_res_ready   (w_res_ready),
        .o_ctrl        (w_ctrl),
        .o_tail        (w_tail),
        .o_res         (w_res)
    );

    // output register parts the head from the consumer
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out.event_entity;
    assign m_axis_tuser  = {r_out.send_discover, r_out.event_res};

endmodule
